// ===== hdl/ssm_pkg.sv =====
// ============================================================================
// Supply and shock monitor package
// Shared types, widths and constants for the supply and shock monitor.
// ============================================================================
package ssm_pkg;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int LEVEL_W  = 13;
    localparam int LIMIT_W  = 16;
    localparam int TIME_W   = 32;
    localparam int CFG_IDX_W = 3;

    // Shared multiplier and magnitude datapath widths
    localparam int MUL_W    = 24;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SUM_W    = 24;
    localparam int ROOT_W   = 12;
    localparam int BIT_IDX_W = 4;

    // Axis midscale and gain of 1.709 as 1709/1000
    localparam logic [SAMPLE_W-1:0] AXIS_MID = 12'd2048;
    localparam logic [MUL_W-1:0]    GAIN_NUM = 24'd1709;
    // Division by 1000 as a multiply by ceil(2^33/1000) and a shift by 33;
    // exact for every product below 2^23.
    localparam logic [MUL_W-1:0]    RECIP_K  = 24'd8589935;
    localparam int                  RECIP_SHIFT = 33;
    localparam int                  GAIN_PROD_W = 23;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_EN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOCK_EN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAIL_EN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOCK_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAIL_LIMIT    = 3'd5;

    // Commands
    localparam logic CMD_PROCESS = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

    // Request to the magnitude sequencer
    typedef struct packed {
        logic                start;
        logic [SAMPLE_W-1:0] ax;
        logic [SAMPLE_W-1:0] ay;
        logic [SAMPLE_W-1:0] az;
    } t_shock_req;

    // Response from the magnitude sequencer
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [LEVEL_W-1:0] level;
    } t_shock_rsp;

endpackage

// ===== hdl/ssm_mul.sv =====
// ============================================================================
// Shared multiplier
// Unsigned multiplier with a registered product, time-shared by the
// magnitude sequencer for squares, root trials and gain scaling.
// ============================================================================
module ssm_mul (
    input  logic                         i_clk,
    input  logic [ssm_pkg::MUL_W-1:0]    i_a,
    input  logic [ssm_pkg::MUL_W-1:0]    i_b,
    output logic [ssm_pkg::PROD_W-1:0]   o_prod
);

    logic [ssm_pkg::PROD_W-1:0] r_prod;

    // Product register, no reset needed for payload.
    always_ff @(posedge i_clk) begin
        r_prod <= ssm_pkg::PROD_W'(i_a) * ssm_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/ssm_shock.sv =====
// ============================================================================
// Shock magnitude sequencer
// Computes floor(isqrt(dx^2 + dy^2 + dz^2) * 1709 / 1000) with one shared
// multiplier: three squares, a 12-bit trial square root, then gain scaling.
// ============================================================================
module ssm_shock (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ssm_pkg::t_shock_req i_req,
    output ssm_pkg::t_shock_rsp o_rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SQZ,
        S_SUM,
        S_RMUL,
        S_RCMP,
        S_GAIN,
        S_RECIP,
        S_DONE
    } t_state;

    t_state                              r_state;
    logic [ssm_pkg::SAMPLE_W-1:0]        r_dx, r_dy, r_dz;
    logic [ssm_pkg::SUM_W-1:0]           r_acc;
    logic [ssm_pkg::ROOT_W-1:0]          r_root;
    logic [ssm_pkg::BIT_IDX_W-1:0]       r_bit;

    logic [ssm_pkg::MUL_W-1:0]           w_a, w_b;
    logic [ssm_pkg::PROD_W-1:0]          w_prod;
    logic [ssm_pkg::ROOT_W-1:0]          w_trial;

    // Distance of one axis reading from midscale.
    function automatic logic [ssm_pkg::SAMPLE_W-1:0] axis_dist(
        input logic [ssm_pkg::SAMPLE_W-1:0] a
    );
        if (a >= ssm_pkg::AXIS_MID) begin
            return a - ssm_pkg::AXIS_MID;
        end else begin
            return ssm_pkg::AXIS_MID - a;
        end
    endfunction

    // Current root candidate with the bit under test set.
    assign w_trial = r_root | (ssm_pkg::ROOT_W'(1) << r_bit);

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_state)
            S_SQX: begin
                w_a = ssm_pkg::MUL_W'(r_dx);
                w_b = ssm_pkg::MUL_W'(r_dx);
            end
            S_SQY: begin
                w_a = ssm_pkg::MUL_W'(r_dy);
                w_b = ssm_pkg::MUL_W'(r_dy);
            end
            S_SQZ: begin
                w_a = ssm_pkg::MUL_W'(r_dz);
                w_b = ssm_pkg::MUL_W'(r_dz);
            end
            S_RMUL: begin
                w_a = ssm_pkg::MUL_W'(w_trial);
                w_b = ssm_pkg::MUL_W'(w_trial);
            end
            S_GAIN: begin
                w_a = ssm_pkg::MUL_W'(r_root);
                w_b = ssm_pkg::GAIN_NUM;
            end
            S_RECIP: begin
                w_a = ssm_pkg::MUL_W'(w_prod[ssm_pkg::GAIN_PROD_W-1:0]);
                w_b = ssm_pkg::RECIP_K;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    ssm_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    // Sequencer: squares, sum, trial root bits, gain and reciprocal scaling.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_root  <= '0;
            r_bit   <= '0;
            r_acc   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_dx    <= axis_dist(i_req.ax);
                        r_dy    <= axis_dist(i_req.ay);
                        r_dz    <= axis_dist(i_req.az);
                        r_state <= S_SQX;
                    end
                end
                S_SQX: begin
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_acc   <= w_prod[ssm_pkg::SUM_W-1:0];
                    r_state <= S_SQZ;
                end
                S_SQZ: begin
                    r_acc   <= r_acc + w_prod[ssm_pkg::SUM_W-1:0];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_acc   <= r_acc + w_prod[ssm_pkg::SUM_W-1:0];
                    r_root  <= '0;
                    r_bit   <= ssm_pkg::BIT_IDX_W'(ssm_pkg::ROOT_W - 1);
                    r_state <= S_RMUL;
                end
                S_RMUL: begin
                    r_state <= S_RCMP;
                end
                S_RCMP: begin
                    // Keep the bit when the trial square does not exceed the sum.
                    if (w_prod <= ssm_pkg::PROD_W'(r_acc)) begin
                        r_root <= w_trial;
                    end
                    if (r_bit == '0) begin
                        r_state <= S_GAIN;
                    end else begin
                        r_bit   <= r_bit - 1'b1;
                        r_state <= S_RMUL;
                    end
                end
                S_GAIN: begin
                    r_state <= S_RECIP;
                end
                S_RECIP: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.busy  = (r_state != S_IDLE);
    assign o_rsp.done  = (r_state == S_DONE);
    assign o_rsp.level = w_prod[ssm_pkg::RECIP_SHIFT +: ssm_pkg::LEVEL_W];

`ifndef SYNTHESIS
    // A root bit index never leaves the 12-bit range.
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMUL || r_state == S_RCMP) |-> (r_bit < ssm_pkg::ROOT_W))
        else $error("root bit index out of range");

    // The magnitude result never exceeds its largest value.
    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (o_rsp.level <= 13'd6061))
        else $error("shock level above maximum");

    // Done follows the reciprocal step.
    a_done_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> $past(r_state == S_RECIP))
        else $error("done without scaling step");
`endif

endmodule

// ===== hdl/supply_and_shock_monitor_unit.sv =====
// ============================================================================
// Supply and shock monitor unit
// Stores battery and rail readings with low-limit flags, computes a scaled
// shock magnitude and latches the time of the first event on each channel.
// ============================================================================
// One transaction in gives one transaction out. A clear command, or a sample
// set with the shock channel disabled, goes from acceptance straight to the
// finish step, and the next transaction can be accepted once the unit is idle
// again. With the shock channel enabled the result waits for the magnitude
// sequencer on one shared 24x24 multiplier: a start pulse, the three squares
// and their sum, twelve square-root trial bits with a multiply and a compare
// step each, two scaling multiplies and a done step, then the finish step.
// The input side is ready only while no item is in work, so the unit takes
// no new item before the last one is finished. A finished item waits in the
// finish step until the previous result is taken, so an output stall holds
// back the next acceptance.
module supply_and_shock_monitor_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [ssm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ssm_pkg::LIMIT_W-1:0]       i_cfg_data,
    // Input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_command,
    input  logic [ssm_pkg::SAMPLE_W-1:0]      i_battery_sample,
    input  logic [ssm_pkg::SAMPLE_W-1:0]      i_accel_x,
    input  logic [ssm_pkg::SAMPLE_W-1:0]      i_accel_y,
    input  logic [ssm_pkg::SAMPLE_W-1:0]      i_accel_z,
    input  logic [ssm_pkg::SAMPLE_W-1:0]      i_rail_sample,
    input  logic [ssm_pkg::TIME_W-1:0]        i_timestamp,
    // Output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ssm_pkg::SAMPLE_W-1:0]      o_battery_level,
    output logic [ssm_pkg::LEVEL_W-1:0]       o_shock_level,
    output logic [ssm_pkg::SAMPLE_W-1:0]      o_rail_level,
    output logic                              o_battery_ok,
    output logic                              o_rail_ok,
    output logic [ssm_pkg::TIME_W-1:0]        o_battery_event_time,
    output logic [ssm_pkg::TIME_W-1:0]        o_shock_event_time,
    output logic [ssm_pkg::TIME_W-1:0]        o_rail_event_time,
    output logic                              o_new_event
);

    typedef enum logic [1:0] {
        T_IDLE,
        T_BUSY,
        T_FIN
    } t_state;

    t_state                          r_state;

    // Configuration registers
    logic                            r_battery_en, r_shock_en, r_rail_en;
    logic [ssm_pkg::SAMPLE_W-1:0]    r_battery_limit, r_rail_limit;
    logic [ssm_pkg::LIMIT_W-1:0]     r_shock_limit;

    // Captured transaction
    logic                            r_cmd;
    logic [ssm_pkg::SAMPLE_W-1:0]    r_bat, r_rail, r_ax, r_ay, r_az;
    logic [ssm_pkg::TIME_W-1:0]      r_ts;
    logic [ssm_pkg::LEVEL_W-1:0]     r_shock_calc;
    logic                            r_start;

    // Monitor state, presented directly as the result
    logic                            r_out_valid;
    logic [ssm_pkg::SAMPLE_W-1:0]    r_stored_battery, r_stored_rail;
    logic [ssm_pkg::LEVEL_W-1:0]     r_stored_shock;
    logic                            r_battery_good, r_rail_good;
    logic [ssm_pkg::TIME_W-1:0]      r_time_battery, r_time_shock, r_time_rail;
    logic                            r_new_event;

    ssm_pkg::t_shock_req             w_req;
    ssm_pkg::t_shock_rsp             w_rsp;

    logic                            w_out_free;
    logic                            w_finish;
    logic                            w_bat_low, w_rail_low, w_shock_hit;
    logic                            w_latch_bat, w_latch_shock, w_latch_rail;

    // Magnitude sequencer
    assign w_req.start = r_start;
    assign w_req.ax    = r_ax;
    assign w_req.ay    = r_ay;
    assign w_req.az    = r_az;

    ssm_shock u_shock (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Event decisions for the item being finished
    assign w_out_free    = !r_out_valid || i_out_ready;
    assign w_finish      = (r_state == T_FIN) && w_out_free;
    assign w_bat_low     = (r_bat < r_battery_limit);
    assign w_rail_low    = (r_rail < r_rail_limit);
    assign w_shock_hit   = (ssm_pkg::LIMIT_W'(r_shock_calc) > r_shock_limit);
    assign w_latch_bat   = r_battery_en && w_bat_low && (r_time_battery == '0);
    assign w_latch_shock = r_shock_en && w_shock_hit && (r_time_shock == '0);
    assign w_latch_rail  = r_rail_en && w_rail_low && (r_time_rail == '0);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_battery_en    <= 1'b0;
            r_shock_en      <= 1'b0;
            r_rail_en       <= 1'b0;
            r_battery_limit <= '0;
            r_shock_limit   <= '0;
            r_rail_limit    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ssm_pkg::CFG_BATTERY_EN:    r_battery_en    <= i_cfg_data[0];
                ssm_pkg::CFG_SHOCK_EN:      r_shock_en      <= i_cfg_data[0];
                ssm_pkg::CFG_RAIL_EN:       r_rail_en       <= i_cfg_data[0];
                ssm_pkg::CFG_BATTERY_LIMIT: r_battery_limit <= i_cfg_data[ssm_pkg::SAMPLE_W-1:0];
                ssm_pkg::CFG_SHOCK_LIMIT:   r_shock_limit   <= i_cfg_data;
                ssm_pkg::CFG_RAIL_LIMIT:    r_rail_limit    <= i_cfg_data[ssm_pkg::SAMPLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Control FSM with the monitor state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= T_IDLE;
            r_start          <= 1'b0;
            r_out_valid      <= 1'b0;
            r_stored_battery <= '0;
            r_stored_shock   <= '0;
            r_stored_rail    <= '0;
            r_battery_good   <= 1'b0;
            r_rail_good      <= 1'b0;
            r_time_battery   <= '0;
            r_time_shock     <= '0;
            r_time_rail      <= '0;
            r_new_event      <= 1'b0;
        end else begin
            r_start <= 1'b0;
            // The result register fills when an item finishes and empties when taken.
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                T_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd  <= i_command;
                        r_bat  <= i_battery_sample;
                        r_rail <= i_rail_sample;
                        r_ax   <= i_accel_x;
                        r_ay   <= i_accel_y;
                        r_az   <= i_accel_z;
                        r_ts   <= i_timestamp;
                        if (i_command == ssm_pkg::CMD_PROCESS && r_shock_en) begin
                            r_start <= 1'b1;
                            r_state <= T_BUSY;
                        end else begin
                            r_state <= T_FIN;
                        end
                    end
                end
                T_BUSY: begin
                    if (w_rsp.done) begin
                        r_shock_calc <= w_rsp.level;
                        r_state      <= T_FIN;
                    end
                end
                T_FIN: begin
                    // Update the state once the previous result is taken.
                    if (w_out_free) begin
                        r_state     <= T_IDLE;
                        if (r_cmd == ssm_pkg::CMD_CLEAR) begin
                            r_time_battery <= '0;
                            r_time_shock   <= '0;
                            r_time_rail    <= '0;
                            r_new_event    <= 1'b0;
                        end else begin
                            if (r_battery_en) begin
                                r_stored_battery <= r_bat;
                                r_battery_good   <= !w_bat_low;
                            end
                            if (r_shock_en) begin
                                r_stored_shock <= r_shock_calc;
                            end
                            if (r_rail_en) begin
                                r_stored_rail <= r_rail;
                                r_rail_good   <= !w_rail_low;
                            end
                            if (w_latch_bat) begin
                                r_time_battery <= r_ts;
                            end
                            if (w_latch_shock) begin
                                r_time_shock <= r_ts;
                            end
                            if (w_latch_rail) begin
                                r_time_rail <= r_ts;
                            end
                            r_new_event <= w_latch_bat || w_latch_shock || w_latch_rail;
                        end
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready           = (r_state == T_IDLE);
    assign o_out_valid          = r_out_valid;
    assign o_battery_level      = r_stored_battery;
    assign o_shock_level        = r_stored_shock;
    assign o_rail_level         = r_stored_rail;
    assign o_battery_ok         = r_battery_good;
    assign o_rail_ok            = r_rail_good;
    assign o_battery_event_time = r_time_battery;
    assign o_shock_event_time   = r_time_shock;
    assign o_rail_event_time    = r_time_rail;
    assign o_new_event          = r_new_event;

`ifndef SYNTHESIS
    // The sequencer only reports completion while an item waits for it.
    a_done_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == T_BUSY))
        else $error("magnitude done outside busy state");

    // A new result appears only when an item is finished.
    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == T_FIN))
        else $error("result raised without finishing an item");

    // A latched battery time holds across any process transaction.
    a_slot_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_FIN && w_out_free && r_cmd == ssm_pkg::CMD_PROCESS
         && r_time_battery != '0) |=> $stable(r_time_battery))
        else $error("latched battery time overwritten");

    // The input side is never ready while the sequencer runs.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.busy |-> !o_in_ready)
        else $error("ready while magnitude sequencer is busy");
`endif

endmodule

// ===== verif/tb_top.sv =====
// ============================================================================
// Supply and shock monitor unit testbench
// Drives sample sets and clear commands through the valid/ready channels,
// predicts every result with a self-contained model of the monitor, and
// compares each transaction field by field. Register settings change between
// phases while the unit is idle. Both channels idle in random bursts.
// ============================================================================
module tb_top;

    // One input transaction: a command with its sample set.
    typedef struct packed {
        logic                         command;
        logic [ssm_pkg::SAMPLE_W-1:0] battery;
        logic [ssm_pkg::SAMPLE_W-1:0] ax;
        logic [ssm_pkg::SAMPLE_W-1:0] ay;
        logic [ssm_pkg::SAMPLE_W-1:0] az;
        logic [ssm_pkg::SAMPLE_W-1:0] rail;
        logic [ssm_pkg::TIME_W-1:0]   stamp;
    } t_sample_set;

    // One output transaction: stored levels, flags and latched event times.
    typedef struct packed {
        logic [ssm_pkg::SAMPLE_W-1:0] battery_level;
        logic [ssm_pkg::LEVEL_W-1:0]  shock_level;
        logic [ssm_pkg::SAMPLE_W-1:0] rail_level;
        logic                         battery_ok;
        logic                         rail_ok;
        logic [ssm_pkg::TIME_W-1:0]   battery_time;
        logic [ssm_pkg::TIME_W-1:0]   shock_time;
        logic [ssm_pkg::TIME_W-1:0]   rail_time;
        logic                         new_event;
    } t_monitor_result;

    // Scoreboard: a copy of the monitor state that predicts each result.
    class monitor_scoreboard;
        bit                           battery_on, shock_on, rail_on;
        logic [ssm_pkg::SAMPLE_W-1:0] battery_min, rail_min;
        logic [ssm_pkg::LIMIT_W-1:0]  shock_max;
        logic [ssm_pkg::SAMPLE_W-1:0] last_battery, last_rail;
        logic [ssm_pkg::LEVEL_W-1:0]  last_shock;
        bit                           battery_good, rail_good;
        logic [ssm_pkg::TIME_W-1:0]   slot_time [3];
        t_monitor_result              expected_q [$];
        int                           errors, n_sets, n_clears, n_fresh, n_checked;
        int                           n_settings;

        function new();
            battery_on = 0; shock_on = 0; rail_on = 0;
            battery_min = '0; rail_min = '0; shock_max = '0;
            last_battery = '0; last_rail = '0; last_shock = '0;
            battery_good = 0; rail_good = 0;
            foreach (slot_time[k]) slot_time[k] = '0;
            errors = 0; n_sets = 0; n_clears = 0; n_fresh = 0; n_checked = 0;
            n_settings = 0;
        endfunction

        function void apply_register(logic [ssm_pkg::CFG_IDX_W-1:0] idx,
                                     logic [ssm_pkg::LIMIT_W-1:0] data);
            case (idx)
                ssm_pkg::CFG_BATTERY_EN:    battery_on = data[0];
                ssm_pkg::CFG_SHOCK_EN:      shock_on = data[0];
                ssm_pkg::CFG_RAIL_EN:       rail_on = data[0];
                ssm_pkg::CFG_BATTERY_LIMIT: battery_min = data[ssm_pkg::SAMPLE_W-1:0];
                ssm_pkg::CFG_SHOCK_LIMIT:   shock_max = data;
                ssm_pkg::CFG_RAIL_LIMIT:    rail_min = data[ssm_pkg::SAMPLE_W-1:0];
                default: ;
            endcase
        endfunction

        // Squared distance of one axis from midscale.
        function int axis_energy(logic [ssm_pkg::SAMPLE_W-1:0] a);
            int d;
            d = (a >= ssm_pkg::AXIS_MID) ? int'(a) - int'(ssm_pkg::AXIS_MID)
                                         : int'(ssm_pkg::AXIS_MID) - int'(a);
            return d * d;
        endfunction

        // Bit-by-bit floor square root of the energy sum.
        function int floor_root(int v);
            int r, t;
            r = 0;
            for (int b = 11; b >= 0; b--) begin
                t = r | (1 << b);
                if (t * t <= v) r = t;
            end
            return r;
        endfunction

        // Latch a slot only while it still reads zero.
        function bit claim_slot(int k, logic [ssm_pkg::TIME_W-1:0] stamp);
            if (slot_time[k] != 0) return 0;
            slot_time[k] = stamp;
            return 1;
        endfunction

        function void note_input(t_sample_set s);
            t_monitor_result r;
            bit              fresh;
            int              level;
            fresh = 0;
            if (s.command == ssm_pkg::CMD_CLEAR) begin
                foreach (slot_time[k]) slot_time[k] = '0;
                n_clears++;
            end else begin
                n_sets++;
                if (battery_on) begin
                    last_battery = s.battery;
                    battery_good = (s.battery >= battery_min);
                    if (!battery_good && claim_slot(0, s.stamp)) fresh = 1;
                end
                if (shock_on) begin
                    level = floor_root(axis_energy(s.ax) + axis_energy(s.ay)
                                       + axis_energy(s.az)) * 1709 / 1000;
                    last_shock = level[ssm_pkg::LEVEL_W-1:0];
                    if (level > int'(shock_max) && claim_slot(1, s.stamp)) fresh = 1;
                end
                if (rail_on) begin
                    last_rail = s.rail;
                    rail_good = (s.rail >= rail_min);
                    if (!rail_good && claim_slot(2, s.stamp)) fresh = 1;
                end
            end
            r.battery_level = last_battery;
            r.shock_level   = last_shock;
            r.rail_level    = last_rail;
            r.battery_ok    = battery_good;
            r.rail_ok       = rail_good;
            r.battery_time  = slot_time[0];
            r.shock_time    = slot_time[1];
            r.rail_time     = slot_time[2];
            r.new_event     = fresh;
            expected_q.push_back(r);
        endfunction

        function int field_diff(string name, logic [31:0] e, logic [31:0] a);
            if (a === e) return 0;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
            return 1;
        endfunction

        function void check_result(t_monitor_result got);
            t_monitor_result e;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no transaction pending, actual %h", $time, got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            n_checked++;
            if (e.new_event) n_fresh++;
            errors += field_diff("battery_level", e.battery_level, got.battery_level);
            errors += field_diff("shock_level", e.shock_level, got.shock_level);
            errors += field_diff("rail_level", e.rail_level, got.rail_level);
            errors += field_diff("battery_ok", e.battery_ok, got.battery_ok);
            errors += field_diff("rail_ok", e.rail_ok, got.rail_ok);
            errors += field_diff("battery_event_time", e.battery_time, got.battery_time);
            errors += field_diff("shock_event_time", e.shock_time, got.shock_time);
            errors += field_diff("rail_event_time", e.rail_time, got.rail_time);
            errors += field_diff("new_event", e.new_event, got.new_event);
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [ssm_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [ssm_pkg::LIMIT_W-1:0]    i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic                           i_command;
    logic [ssm_pkg::SAMPLE_W-1:0]   i_battery_sample;
    logic [ssm_pkg::SAMPLE_W-1:0]   i_accel_x;
    logic [ssm_pkg::SAMPLE_W-1:0]   i_accel_y;
    logic [ssm_pkg::SAMPLE_W-1:0]   i_accel_z;
    logic [ssm_pkg::SAMPLE_W-1:0]   i_rail_sample;
    logic [ssm_pkg::TIME_W-1:0]     i_timestamp;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic [ssm_pkg::SAMPLE_W-1:0]   o_battery_level;
    logic [ssm_pkg::LEVEL_W-1:0]    o_shock_level;
    logic [ssm_pkg::SAMPLE_W-1:0]   o_rail_level;
    logic                           o_battery_ok;
    logic                           o_rail_ok;
    logic [ssm_pkg::TIME_W-1:0]     o_battery_event_time;
    logic [ssm_pkg::TIME_W-1:0]     o_shock_event_time;
    logic [ssm_pkg::TIME_W-1:0]     o_rail_event_time;
    logic                           o_new_event;

    monitor_scoreboard          board;
    bit                         calm;
    int                         stall_left;
    logic [ssm_pkg::TIME_W-1:0] stamp_now;

    supply_and_shock_monitor_unit uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_command            (i_command),
        .i_battery_sample     (i_battery_sample),
        .i_accel_x            (i_accel_x),
        .i_accel_y            (i_accel_y),
        .i_accel_z            (i_accel_z),
        .i_rail_sample        (i_rail_sample),
        .i_timestamp          (i_timestamp),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_battery_level      (o_battery_level),
        .o_shock_level        (o_shock_level),
        .o_rail_level         (o_rail_level),
        .o_battery_ok         (o_battery_ok),
        .o_rail_ok            (o_rail_ok),
        .o_battery_event_time (o_battery_event_time),
        .o_shock_event_time   (o_shock_event_time),
        .o_rail_event_time    (o_rail_event_time),
        .o_new_event          (o_new_event)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog for a hung run.
    initial begin
        #10_000_000;
        $display("%0t: run stopped by the watchdog", $time);
        $display("CHECK FAILED");
        $finish;
    end

    // Result side ready, with random stall bursts unless the run is calm.
    initial begin
        i_out_ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_out_ready = 1'b0;
                stall_left = $urandom_range(0, 4);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // Every accepted result transaction goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_result('{o_battery_level, o_shock_level, o_rail_level,
                                 o_battery_ok, o_rail_ok, o_battery_event_time,
                                 o_shock_event_time, o_rail_event_time, o_new_event});
        end
    end

    // Register write; called at a falling edge while the unit is idle.
    task automatic program_register(input logic [ssm_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [ssm_pkg::LIMIT_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        board.apply_register(idx, data);
    endtask

    // Send one transaction and hold it until accepted, then maybe pause.
    task automatic send_set(input t_sample_set s);
        i_in_valid       = 1'b1;
        i_command        = s.command;
        i_battery_sample = s.battery;
        i_accel_x        = s.ax;
        i_accel_y        = s.ay;
        i_accel_z        = s.az;
        i_rail_sample    = s.rail;
        i_timestamp      = s.stamp;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_input(s);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
    endtask

    // Drain all pending results and let the unit settle before a write.
    task automatic settle();
        i_in_valid = 1'b0;
        while (board.expected_q.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    function automatic t_sample_set build(logic cmd, int bat, int ax, int ay, int az,
                                          int rail, logic [ssm_pkg::TIME_W-1:0] ts);
        t_sample_set s;
        s.command = cmd;
        s.battery = bat[ssm_pkg::SAMPLE_W-1:0];
        s.ax      = ax[ssm_pkg::SAMPLE_W-1:0];
        s.ay      = ay[ssm_pkg::SAMPLE_W-1:0];
        s.az      = az[ssm_pkg::SAMPLE_W-1:0];
        s.rail    = rail[ssm_pkg::SAMPLE_W-1:0];
        s.stamp   = ts;
        return s;
    endfunction

    // Reading close to a limit, clamped to the converter range.
    function automatic int near_limit(int limit);
        int v;
        v = limit + $urandom_range(0, 6) - 3;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v;
    endfunction

    function automatic int pick_reading(int limit);
        case ($urandom_range(0, 5))
            0: return near_limit(limit);
            1: return near_limit(limit);
            2: return ($urandom_range(0, 1) != 0) ? 4095 : 0;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic int pick_axis();
        case ($urandom_range(0, 4))
            0: return 2048 + $urandom_range(0, 1200) - 600;
            1: return ($urandom_range(0, 1) != 0) ? 4095 : 0;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    // Random transaction: mostly sample sets, with clears now and then.
    function automatic t_sample_set random_set();
        logic [ssm_pkg::TIME_W-1:0] ts;
        case ($urandom_range(0, 19))
            0: ts = '0;
            1: ts = $urandom;
            default: begin
                stamp_now = stamp_now + $urandom_range(1, 1000);
                ts = stamp_now;
            end
        endcase
        return build(($urandom_range(0, 11) == 0) ? ssm_pkg::CMD_CLEAR : ssm_pkg::CMD_PROCESS,
                     pick_reading(board.battery_min), pick_axis(), pick_axis(), pick_axis(),
                     pick_reading(board.rail_min), ts);
    endfunction

    // Register setting for one random phase; the first two are the extremes.
    task automatic configure_phase(input int p);
        logic [ssm_pkg::LIMIT_W-1:0] noise;
        int                          shock_lim;
        noise = $urandom;
        if (p < 2) begin
            program_register(ssm_pkg::CFG_BATTERY_EN, {noise[15:1], 1'b1});
            program_register(ssm_pkg::CFG_SHOCK_EN, 16'h0001);
            program_register(ssm_pkg::CFG_RAIL_EN, 16'h0001);
            program_register(ssm_pkg::CFG_BATTERY_LIMIT, (p == 0) ? 16'h0000 : 16'hFFFF);
            program_register(ssm_pkg::CFG_SHOCK_LIMIT, (p == 0) ? 16'h0000 : 16'hFFFF);
            program_register(ssm_pkg::CFG_RAIL_LIMIT,
                             (p == 0) ? {noise[15:12], 12'h000} : 16'h0FFF);
        end else begin
            case ($urandom_range(0, 5))
                0: shock_lim = 0;
                1: shock_lim = 65535;
                default: shock_lim = $urandom_range(0, 6100);
            endcase
            program_register(ssm_pkg::CFG_BATTERY_EN,
                             {noise[15:1], ($urandom_range(0, 3) != 0)});
            program_register(ssm_pkg::CFG_SHOCK_EN,
                             {noise[14:0], ($urandom_range(0, 3) != 0)});
            program_register(ssm_pkg::CFG_RAIL_EN,
                             {noise[13:0], noise[15], ($urandom_range(0, 3) != 0)});
            program_register(ssm_pkg::CFG_BATTERY_LIMIT,
                             {noise[3:0], 12'($urandom_range(0, 4095))});
            program_register(ssm_pkg::CFG_SHOCK_LIMIT, 16'(shock_lim));
            program_register(ssm_pkg::CFG_RAIL_LIMIT,
                             {noise[7:4], 12'($urandom_range(0, 4095))});
        end
        board.n_settings++;
    endtask

    // Main sequence.
    initial begin
        board            = new();
        calm             = 1'b0;
        stamp_now        = 32'd1;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_command        = ssm_pkg::CMD_PROCESS;
        i_battery_sample = '0;
        i_accel_x        = '0;
        i_accel_y        = '0;
        i_accel_z        = '0;
        i_rail_sample    = '0;
        i_timestamp      = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part: all channels on, supply limits at midscale, shock limit 999.
        program_register(ssm_pkg::CFG_BATTERY_EN, 16'h0001);
        program_register(ssm_pkg::CFG_SHOCK_EN, 16'h0001);
        program_register(ssm_pkg::CFG_RAIL_EN, 16'h0001);
        program_register(ssm_pkg::CFG_BATTERY_LIMIT, 16'd2048);
        program_register(ssm_pkg::CFG_SHOCK_LIMIT, 16'd999);
        program_register(ssm_pkg::CFG_RAIL_LIMIT, 16'd2048);
        // Index values beyond the register list must be ignored.
        program_register(ssm_pkg::CFG_RAIL_LIMIT + 3'd1, 16'hFFFF);
        program_register(ssm_pkg::CFG_RAIL_LIMIT + 3'd2, 16'hFFFF);
        board.n_settings++;
        // Quiet axes and full readings: no event.
        send_set(build(ssm_pkg::CMD_PROCESS, 4095, 2048, 2048, 2048, 4095, 32'd100));
        // Largest magnitude and empty supplies at time zero: slots stay free.
        send_set(build(ssm_pkg::CMD_PROCESS, 0, 0, 0, 0, 0, 32'd0));
        // Events latch the largest time stamp.
        send_set(build(ssm_pkg::CMD_PROCESS, 2047, 4095, 4095, 4095, 2047, 32'hFFFF_FFFF));
        // Later events leave latched slots alone.
        send_set(build(ssm_pkg::CMD_PROCESS, 100, 4095, 0, 4095, 5, 32'd5));
        send_set(build(ssm_pkg::CMD_CLEAR, $urandom_range(0, 4095), 0, 4095, 0,
                       $urandom_range(0, 4095), $urandom));
        // Readings exactly at the limits are good; level 999 is not a shock.
        send_set(build(ssm_pkg::CMD_PROCESS, 2048, 2633, 2048, 2048, 2048, 32'd7));
        // Level 1001 is just above the shock limit.
        send_set(build(ssm_pkg::CMD_PROCESS, 2049, 2048, 2048, 2634, 3000, 32'd8));
        send_set(build(ssm_pkg::CMD_PROCESS, 2047, 2048, 1462, 2048, 4095, 32'd9));
        send_set(build(ssm_pkg::CMD_PROCESS, 4095, 2048, 2048, 2048, 2047, 32'd10));
        send_set(build(ssm_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 32'd0));
        send_set(build(ssm_pkg::CMD_CLEAR, 4095, 4095, 4095, 4095, 4095, 32'hFFFF_FFFF));
        settle();

        // Directed part: every channel off, so nothing may change.
        program_register(ssm_pkg::CFG_BATTERY_EN, 16'hFFFE);
        program_register(ssm_pkg::CFG_SHOCK_EN, 16'hFFFE);
        program_register(ssm_pkg::CFG_RAIL_EN, 16'hFFFE);
        program_register(ssm_pkg::CFG_BATTERY_LIMIT, 16'hFFFF);
        program_register(ssm_pkg::CFG_SHOCK_LIMIT, 16'hFFFF);
        program_register(ssm_pkg::CFG_RAIL_LIMIT, 16'hFFFF);
        board.n_settings++;
        send_set(build(ssm_pkg::CMD_PROCESS, 0, 0, 0, 0, 0, 32'd11));
        send_set(build(ssm_pkg::CMD_PROCESS, 4095, 4095, 4095, 4095, 4095, 32'd12));
        send_set(build(ssm_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 32'd13));
        settle();

        // Random phases; some run without idling, the last one as well.
        for (int p = 0; p < 8; p++) begin
            calm = (p == 3) || (p == 7);
            configure_phase(p);
            repeat (220) send_set(random_set());
            settle();
        end

        if (board.expected_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, board.expected_q.size());
            board.errors++;
        end
        $display("Covered %0d sample sets and %0d clear commands under %0d register settings.",
                 board.n_sets, board.n_clears, board.n_settings);
        $display("Checked %0d results, %0d of which latched a new event time.",
                 board.n_checked, board.n_fresh);
        if (board.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ssm_pkg.sv
hdl/ssm_mul.sv
hdl/ssm_shock.sv
hdl/supply_and_shock_monitor_unit.sv
verif/tb_top.sv
